// ===== hdl/console_line_edit_buffer_defines.svh =====
// Assertion helpers for the line edit buffer.
`ifndef CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH
`define CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH

// same-cycle implication
`define CLEB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLEB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cleb_pkg.sv =====
package cleb_pkg;

	localparam int LINE_CHARS = 256;
	localparam int AW = $clog2(LINE_CHARS);
	localparam int CW = $clog2(LINE_CHARS + 1);

	localparam logic [7:0] KEY_PREFIX    = 8'd224;
	localparam logic [7:0] KEY_HOME      = 8'd71;
	localparam logic [7:0] KEY_END       = 8'd79;
	localparam logic [7:0] KEY_LEFT      = 8'd75;
	localparam logic [7:0] KEY_RIGHT     = 8'd77;
	localparam logic [7:0] KEY_DELETE    = 8'd83;
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_ENTER     = 8'd13;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RDATA,
		ST_SHIFT,
		ST_CLEAR,
		ST_RESP
	} state_t;

endpackage

// ===== hdl/cleb_ram.sv =====
module cleb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/console_line_edit_buffer.sv =====
// Line editor fed one keyboard byte per word (tuser = 1 reads back a stored character).
// Every input word gives exactly one result word. Keys and typing go through ST_EXEC and
// ST_RESP, a read through ST_READ, ST_RDATA and ST_RESP. Delete and Backspace move the tail of
// the line one character left through the line memory (one write port, one read port) at one
// character per cycle in ST_SHIFT, then clear the vacated slot in ST_CLEAR.
// The input side is ready whenever the editor is idle; a result waiting in the output
// register does not hold off the next word. Line memory contents are undefined until typed.
module console_line_edit_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // key_code[7:0], read_index[15:8]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // cursor_pos[8:0], line_length[17:9], line_done[18],
	                                   // read_char[26:19], status[28:27], zero fill
);

	import cleb_pkg::*;

	`include "console_line_edit_buffer_defines.svh"

	state_t          state_q, state_d;
	logic [CW-1:0]   cur_q, cur_d;
	logic [CW-1:0]   len_q, len_d;
	logic [CW-1:0]   rd_q, rd_d;
	logic            prefix_q, prefix_d;
	logic            fin_q, fin_d;
	logic            shv_s1, shv_d;
	logic            m_valid_q;
	logic            load;

	logic            mode_q;
	logic [7:0]      code_q;
	logic [7:0]      idx_q;
	status_t         stat_q, stat_d;
	logic [7:0]      rchar_q, rchar_d;
	logic [AW-1:0]   wa_s1;
	logic [31:0]     m_data_q;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	logic            accept;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	cleb_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		len_d     = len_q;
		rd_d      = rd_q;
		prefix_d  = prefix_q;
		fin_d     = fin_q;
		shv_d     = 1'b0;
		stat_d    = stat_q;
		rchar_d   = rchar_q;
		load      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_q[AW-1:0];
		ram_wdata = code_q;
		ram_re    = 1'b0;
		ram_raddr = rd_q[AW-1:0];

		// shifted character lands one slot left of where it was read
		if (shv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = ram_rdata;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = s_axis_tuser ? ST_READ : ST_EXEC;
				end
			end
			ST_EXEC: begin
				stat_d  = STAT_OK;
				rchar_d = 8'd0;
				state_d = ST_RESP;
				if (fin_q) begin
					stat_d = STAT_IGNORED;
				end else if (prefix_q) begin
					prefix_d = 1'b0;
					case (code_q)
						KEY_HOME: cur_d = '0;
						KEY_END:  cur_d = len_q;
						KEY_LEFT: begin
							if (cur_q == '0) stat_d = STAT_IGNORED;
							else cur_d = cur_q - 1'b1;
						end
						KEY_RIGHT: begin
							if (cur_q >= len_q) stat_d = STAT_IGNORED;
							else cur_d = cur_q + 1'b1;
						end
						KEY_DELETE: begin
							if (cur_q >= len_q) begin
								stat_d = STAT_IGNORED;
							end else begin
								rd_d    = cur_q + 1'b1;
								state_d = ST_SHIFT;
							end
						end
						default: stat_d = STAT_IGNORED;
					endcase
				end else if (code_q == KEY_PREFIX) begin
					prefix_d = 1'b1;
				end else if (code_q == KEY_BACKSPACE) begin
					if (cur_q == '0) begin
						stat_d = STAT_IGNORED;
					end else begin
						cur_d   = cur_q - 1'b1;
						rd_d    = cur_q;
						state_d = ST_SHIFT;
					end
				end else if (code_q == KEY_ENTER) begin
					fin_d = 1'b1;
				end else if (cur_q < len_q) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[AW-1:0];
					ram_wdata = code_q;
					cur_d     = cur_q + 1'b1;
				end else if (len_q >= CW'(LINE_CHARS)) begin
					stat_d = STAT_FULL;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[AW-1:0];
					ram_wdata = code_q;
					cur_d     = cur_q + 1'b1;
					len_d     = len_q + 1'b1;
				end
			end
			ST_READ: begin
				stat_d  = STAT_OK;
				rchar_d = 8'd0;
				if (32'(idx_q) < LINE_CHARS) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q);
					state_d   = ST_RDATA;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RDATA: begin
				rchar_d = ram_rdata;
				state_d = ST_RESP;
			end
			ST_SHIFT: begin
				if (rd_q < len_q) begin
					ram_re    = 1'b1;
					ram_raddr = rd_q[AW-1:0];
					rd_d      = rd_q + 1'b1;
					shv_d     = 1'b1;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				// vacated slot past the new end reads as zero
				ram_we    = 1'b1;
				ram_waddr = AW'(len_q - 1'b1);
				ram_wdata = 8'd0;
				len_d     = len_q - 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			len_q     <= '0;
			rd_q      <= '0;
			prefix_q  <= 1'b0;
			fin_q     <= 1'b0;
			shv_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			cur_q    <= cur_d;
			len_q    <= len_d;
			rd_q     <= rd_d;
			prefix_q <= prefix_d;
			fin_q    <= fin_d;
			shv_s1   <= shv_d;
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_axis_tuser;
			code_q <= s_axis_tdata[7:0];
			idx_q  <= s_axis_tdata[15:8];
		end
		stat_q  <= stat_d;
		rchar_q <= rchar_d;
		wa_s1   <= AW'(rd_q - 1'b1);
		if (load) begin
			m_data_q <= {3'd0, stat_q, rchar_q, fin_q, 9'(len_q), 9'(cur_q)};
		end
	end

	`CLEB_ASSERT_NOW(a_cur_in_line, 1'b1, cur_q <= len_q, "cursor past line end")
	`CLEB_ASSERT_NOW(a_len_bound, 1'b1, len_q <= CW'(LINE_CHARS), "line length over capacity")
	`CLEB_ASSERT_NOW(a_ram_no_clash, ram_we && ram_re, ram_waddr != ram_raddr,
		"line memory read and write hit the same entry")
	`CLEB_ASSERT_NEXT(a_fin_sticky, fin_q, fin_q, "line done flag dropped without reset")
	`CLEB_ASSERT_NOW(a_read_mode_only, state_q == ST_READ, mode_q,
		"read state entered for a key word")

endmodule
